// ----- sv/playfair_digraph_cipher_assert.svh -----
// -----------------------------------------------------------------------------
// Playfair digraph cipher assertion macros
// Shared concurrent assertion forms for the cipher RTL.
// -----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define PFC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PFC_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/pfc_pkg.sv -----
// -----------------------------------------------------------------------------
// Playfair digraph cipher package
// Table geometry, character constants and shared types.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

  localparam int TABLE_SIDE = 6;
  localparam int ROW_REGS   = 6;
  localparam int ROW_CELLS  = 6;
  localparam int CHAR_W     = 8;
  localparam int ROW_W      = ROW_CELLS * CHAR_W;
  localparam int CFG_IDX_W  = $clog2(ROW_REGS);
  localparam int POS_W      = $clog2(TABLE_SIDE);

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef char_t [TABLE_SIDE-1:0][TABLE_SIDE-1:0] table_t;

  localparam char_t PAD_CHAR     = 8'h58;
  localparam char_t ALT_PAD_CHAR = 8'h5A;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  typedef struct packed {
    logic found;
    pos_t row;
    pos_t col;
  } loc_t;

  typedef struct packed {
    op_t   op;
    char_t first;
    char_t second;
    logic  present;
  } digraph_t;

  typedef struct packed {
    char_t first;
    char_t second;
    logic  err;
  } result_t;

  // One place forward on encrypt, one back on decrypt, wrapping at the table edge.
  function automatic pos_t step_pos(pos_t p, logic dec);
    pos_t q;
    if (dec) begin
      q = (p == '0) ? pos_t'(TABLE_SIDE - 1) : p - pos_t'(1);
    end else begin
      q = (p == pos_t'(TABLE_SIDE - 1)) ? '0 : p + pos_t'(1);
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ----- sv/pfc_key_regs.sv -----
// -----------------------------------------------------------------------------
// Playfair key table registers
// Six row registers written through the configuration port, unpacked to cells.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_key_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfc_pkg::ROW_W-1:0]      cfg_data,
  output pfc_pkg::table_t                key_table
);
  import pfc_pkg::*;

  logic [ROW_W-1:0] key_row [ROW_REGS];
  logic             index_ok;

  assign index_ok = {1'b0, cfg_index} < (CFG_IDX_W + 1)'(ROW_REGS);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROW_REGS; i++) begin
        key_row[i] <= '0;
      end
    end else if (cfg_we && index_ok) begin
      key_row[cfg_index] <= cfg_data;
    end
  end

  // Cells beyond the stored rows or columns read as zero.
  for (genvar r = 0; r < TABLE_SIDE; r++) begin : g_row
    for (genvar c = 0; c < TABLE_SIDE; c++) begin : g_col
      if (r < ROW_REGS && c < ROW_CELLS) begin : g_cell
        assign key_table[r][c] = key_row[r][CHAR_W*c +: CHAR_W];
      end else begin : g_zero
        assign key_table[r][c] = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/pfc_locate.sv -----
// -----------------------------------------------------------------------------
// Playfair character locator
// Compares one character against every table cell and returns its first place.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_locate (
  input  pfc_pkg::table_t key_table,
  input  pfc_pkg::char_t  ch,
  output pfc_pkg::loc_t   loc
);
  import pfc_pkg::*;

  // Scanning from the last cell back leaves the first match in row-major order.
  always_comb begin
    loc = '0;
    for (int r = TABLE_SIDE - 1; r >= 0; r--) begin
      for (int c = TABLE_SIDE - 1; c >= 0; c--) begin
        if (key_table[r][c] == ch) begin
          loc.found = 1'b1;
          loc.row   = pos_t'(r);
          loc.col   = pos_t'(c);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/pfc_digraph_map.sv -----
// -----------------------------------------------------------------------------
// Playfair digraph mapper
// Pads the pair, locates both characters and applies the row, column or
// rectangle rule.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_digraph_map (
  input  pfc_pkg::table_t   key_table,
  input  pfc_pkg::digraph_t item,
  output pfc_pkg::result_t  res
);
  import pfc_pkg::*;

  logic  dec;
  char_t second_eff;
  loc_t  loc_a;
  loc_t  loc_b;

  assign dec = (item.op == OP_DECRYPT);

  always_comb begin
    second_eff = item.second;
    if (!dec) begin
      if (!item.present) begin
        second_eff = PAD_CHAR;
      end
      if (item.first == second_eff) begin
        second_eff = (second_eff != PAD_CHAR) ? PAD_CHAR : ALT_PAD_CHAR;
      end
    end
  end

  pfc_locate u_locate_a (
    .key_table (key_table),
    .ch        (item.first),
    .loc       (loc_a)
  );

  pfc_locate u_locate_b (
    .key_table (key_table),
    .ch        (second_eff),
    .loc       (loc_b)
  );

  always_comb begin
    res = '0;
    if (dec && !item.present) begin
      res.err = 1'b1;
    end else if (!loc_a.found || !loc_b.found) begin
      res.err = 1'b1;
    end else if (loc_a.row == loc_b.row) begin
      res.first  = key_table[loc_a.row][step_pos(loc_a.col, dec)];
      res.second = key_table[loc_a.row][step_pos(loc_b.col, dec)];
    end else if (loc_a.col == loc_b.col) begin
      res.first  = key_table[step_pos(loc_a.row, dec)][loc_a.col];
      res.second = key_table[step_pos(loc_b.row, dec)][loc_a.col];
    end else begin
      res.first  = key_table[loc_a.row][loc_b.col];
      res.second = key_table[loc_b.row][loc_a.col];
    end
  end

endmodule

`default_nettype wire

// ----- sv/playfair_digraph_cipher.sv -----
// -----------------------------------------------------------------------------
// Playfair digraph cipher
// Encrypts or decrypts one digraph per transfer through a 6x6 key table.
// -----------------------------------------------------------------------------
// The block takes one digraph transfer in every cycle while in_stall is low.
// Each result is set by a single combinational pass, padding, two parallel
// searches of the 36 table cells and the rule select, between the input
// register and the result register. The user must load the key rows through
// the write port only while no digraph is in flight; the block itself does
// not enforce this. A character absent from the table, or a decrypt pair
// without its second character, returns lookup_error, both characters zero.
`timescale 1ns / 1ps
`default_nettype none
`include "playfair_digraph_cipher_assert.svh"

module playfair_digraph_cipher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfc_pkg::ROW_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           op,
  input  logic [pfc_pkg::CHAR_W-1:0]     first_char,
  input  logic [pfc_pkg::CHAR_W-1:0]     second_char,
  input  logic                           second_present,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pfc_pkg::CHAR_W-1:0]     out_first,
  output logic [pfc_pkg::CHAR_W-1:0]     out_second,
  output logic                           lookup_error
);
  import pfc_pkg::*;

  table_t   key_table;
  logic     s1_valid;
  digraph_t s1_item;
  result_t  map_res;
  result_t  out_res;
  logic     advance;

  pfc_key_regs u_key_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_table (key_table)
  );

  pfc_digraph_map u_map (
    .key_table (key_table),
    .item      (s1_item),
    .res       (map_res)
  );

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= '{op: op_t'(op), first: first_char, second: second_char,
                   present: second_present};
    end
    if (advance && s1_valid) begin
      out_res <= map_res;
    end
  end

  assign out_first    = out_res.first;
  assign out_second   = out_res.second;
  assign lookup_error = out_res.err;

  `PFC_CHECK(a_error_zero, out_valid && lookup_error |-> out_first == '0 && out_second == '0, "error result carries nonzero characters")
  `PFC_CHECK(a_stall_full, in_stall |-> s1_valid && out_valid && out_stall, "input stalled with room in the pipeline")
  `PFC_CHECK(a_advance, s1_valid && !out_valid |=> out_valid, "held item did not reach the output register")
  `PFC_CHECK(a_dec_missing, s1_valid && s1_item.op == OP_DECRYPT && !s1_item.present |-> map_res.err, "incomplete decrypt pair not flagged")
  `PFC_CHECK_RST(a_reset_empty, rst |=> !s1_valid && !out_valid, "pipeline not empty after reset")

endmodule

`default_nettype wire

// ----- test/playfair_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Playfair digraph cipher checker
// Follows the key row writes and predicts the result of every digraph
// transfer from its own copy of the 6x6 table. It compares each result
// transfer, field by field, with the oldest prediction.
// -----------------------------------------------------------------------------

module playfair_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfc_pkg::ROW_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          op,
  input  logic [pfc_pkg::CHAR_W-1:0]    first_char,
  input  logic [pfc_pkg::CHAR_W-1:0]    second_char,
  input  logic                          second_present,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pfc_pkg::CHAR_W-1:0]    out_first,
  input  logic [pfc_pkg::CHAR_W-1:0]    out_second,
  input  logic                          lookup_error,
  output int                            fail_count,
  output int                            pending,
  output int                            checked,
  output int                            flagged
);

  import pfc_pkg::*;

  logic [ROW_W-1:0] key_rows [ROW_REGS];
  result_t          awaited [$];

  function automatic char_t cell_at(int r, int c);
    return key_rows[r][CHAR_W*c +: CHAR_W];
  endfunction

  function automatic bit find_char(char_t ch, output int r, output int c);
    bit hit;
    hit = 1'b0;
    r = 0;
    c = 0;
    for (int i = 0; i < TABLE_SIDE * TABLE_SIDE; i++) begin
      if (!hit && cell_at(i / TABLE_SIDE, i % TABLE_SIDE) == ch) begin
        hit = 1'b1;
        r = i / TABLE_SIDE;
        c = i % TABLE_SIDE;
      end
    end
    return hit;
  endfunction

  function automatic result_t cipher_pair(op_t mode, char_t a, char_t b, logic present);
    result_t res;
    char_t   pb;
    int      ra, ca, rb, cb, fw;
    res = '0;
    pb = b;
    ra = 0;
    ca = 0;
    rb = 0;
    cb = 0;
    if (mode == OP_DECRYPT) begin
      if (!present) begin
        res.err = 1'b1;
        return res;
      end
    end else begin
      if (!present) pb = PAD_CHAR;
      if (a == pb) pb = (pb != PAD_CHAR) ? PAD_CHAR : ALT_PAD_CHAR;
    end
    if (!find_char(a, ra, ca) || !find_char(pb, rb, cb)) begin
      res.err = 1'b1;
      return res;
    end
    fw = (mode == OP_DECRYPT) ? TABLE_SIDE - 1 : 1;
    if (ra == rb) begin
      res.first  = cell_at(ra, (ca + fw) % TABLE_SIDE);
      res.second = cell_at(ra, (cb + fw) % TABLE_SIDE);
    end else if (ca == cb) begin
      res.first  = cell_at((ra + fw) % TABLE_SIDE, ca);
      res.second = cell_at((rb + fw) % TABLE_SIDE, ca);
    end else begin
      res.first  = cell_at(ra, cb);
      res.second = cell_at(rb, ca);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int i = 0; i < ROW_REGS; i++) key_rows[i] = '0;
      awaited.delete();
      fail_count = 0;
      checked = 0;
      flagged = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $error("result transfer with nothing expected: out_first %h out_second %h err %b",
                 out_first, out_second, lookup_error);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          checked++;
          if (want.err) flagged++;
          if (out_first !== want.first) begin
            $error("out_first: expected %h, actual %h", want.first, out_first);
            fail_count++;
          end
          if (out_second !== want.second) begin
            $error("out_second: expected %h, actual %h", want.second, out_second);
            fail_count++;
          end
          if (lookup_error !== want.err) begin
            $error("lookup_error: expected %b, actual %b", want.err, lookup_error);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        awaited.push_back(cipher_pair(op_t'(op), first_char, second_char, second_present));
      end
      if (cfg_we && cfg_index < ROW_REGS) key_rows[cfg_index] = cfg_data;
    end
    pending = awaited.size();
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Playfair digraph cipher testbench
// Uses a series of key tables, among them the all-zero reset table and an all-ones
// one, and sends directed and random digraphs with random gaps and output
// stalls, including one long output hold-off that backs up the input.
// -----------------------------------------------------------------------------

module testbench;

  import pfc_pkg::*;

  localparam int LONG_HOLD = 300;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ROW_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 op;
  char_t                first_char;
  char_t                second_char;
  logic                 second_present;
  logic                 out_valid;
  logic                 out_stall;
  char_t                out_first;
  char_t                out_second;
  logic                 lookup_error;

  int fail_count, pending, checked, flagged;
  int items_sent, tables_loaded;
  bit squeeze_req, no_gaps;

  logic [ROW_W-1:0] key_img   [ROW_REGS];
  logic [ROW_W-1:0] next_rows [ROW_REGS];

  playfair_digraph_cipher uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .first_char(first_char), .second_char(second_char),
    .second_present(second_present),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first(out_first), .out_second(out_second), .lookup_error(lookup_error)
  );

  playfair_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .first_char(first_char), .second_char(second_char),
    .second_present(second_present),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first(out_first), .out_second(out_second), .lookup_error(lookup_error),
    .fail_count(fail_count), .pending(pending), .checked(checked), .flagged(flagged)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Output side: random stall runs, and one long hold-off on request.
  initial begin
    int r, n;
    bit v;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (squeeze_req) begin
        v = 1'b1;
        n = LONG_HOLD;
        squeeze_req = 1'b0;
      end else if (r < 55) begin
        v = 1'b0;
        n = $urandom_range(1, 6);
      end else if (r < 62) begin
        v = 1'b0;
        n = $urandom_range(30, 80);
      end else if (r < 90) begin
        v = 1'b1;
        n = $urandom_range(1, 3);
      end else if (r < 98) begin
        v = 1'b1;
        n = $urandom_range(4, 10);
      end else begin
        v = 1'b1;
        n = $urandom_range(20, 50);
      end
      out_stall <= v;
      repeat (n - 1) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  function automatic char_t pick_char();
    int r, row, col;
    r = $urandom_range(0, 99);
    row = $urandom_range(0, ROW_REGS - 1);
    col = $urandom_range(0, ROW_CELLS - 1);
    if (r < 70) return key_img[row][CHAR_W*col +: CHAR_W];
    if (r < 85) return ($urandom_range(0, 1) == 0) ? PAD_CHAR : ALT_PAD_CHAR;
    return char_t'($urandom_range(0, 255));
  endfunction

  task automatic offer(logic mode, char_t a, char_t b, logic present);
    int n;
    n = pick_gap();
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    op             <= mode;
    first_char     <= a;
    second_char    <= b;
    second_present <= present;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [ROW_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < ROW_REGS) key_img[idx] = data;
  endtask

  // Writes the staged rows, plus the two unused indexes, which must be ignored.
  task automatic load_table();
    for (int i = 0; i < ROW_REGS; i++) write_reg(i, next_rows[i]);
    for (int i = ROW_REGS; i < (1 << CFG_IDX_W); i++) begin
      write_reg(i, ROW_W'({$urandom(), $urandom()}));
    end
    tables_loaded++;
  endtask

  task automatic build_alphabet(bit shuffle);
    string alphabet;
    byte   chars [TABLE_SIDE*TABLE_SIDE];
    byte   t;
    int    j;
    alphabet = "ABCDEFGHIJKLMNOPRSTUVWXYZ*0123456789";
    for (int i = 0; i < TABLE_SIDE * TABLE_SIDE; i++) chars[i] = alphabet[i];
    if (shuffle) begin
      for (int i = TABLE_SIDE * TABLE_SIDE - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = chars[i];
        chars[i] = chars[j];
        chars[j] = t;
      end
    end
    for (int i = 0; i < TABLE_SIDE * TABLE_SIDE; i++) begin
      next_rows[i / TABLE_SIDE][CHAR_W*(i % TABLE_SIDE) +: CHAR_W] = chars[i];
    end
  endtask

  // Random bytes with a few forced duplicates; the sparse form adds zeros.
  task automatic build_random(bit sparse);
    int r0, c0, r1, c1;
    for (int r = 0; r < ROW_REGS; r++) begin
      for (int c = 0; c < ROW_CELLS; c++) begin
        if (sparse && $urandom_range(0, 2) == 0) begin
          next_rows[r][CHAR_W*c +: CHAR_W] = '0;
        end else if (sparse) begin
          next_rows[r][CHAR_W*c +: CHAR_W] = 8'h80 | char_t'($urandom_range(0, 127));
        end else begin
          next_rows[r][CHAR_W*c +: CHAR_W] = char_t'($urandom_range(0, 255));
        end
      end
    end
    repeat (4) begin
      r0 = $urandom_range(0, ROW_REGS - 1);
      c0 = $urandom_range(0, ROW_CELLS - 1);
      r1 = $urandom_range(0, ROW_REGS - 1);
      c1 = $urandom_range(0, ROW_CELLS - 1);
      next_rows[r1][CHAR_W*c1 +: CHAR_W] = next_rows[r0][CHAR_W*c0 +: CHAR_W];
    end
  endtask

  task automatic random_pairs(int count, bit fast);
    char_t a, b;
    logic  mode, present;
    for (int i = 0; i < count; i++) begin
      if (fast) no_gaps = 1'b1;
      else if (i % 32 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      a = pick_char();
      b = ($urandom_range(0, 4) == 0) ? a : pick_char();
      mode = 1'($urandom_range(0, 1));
      present = ($urandom_range(0, 9) != 0);
      offer(mode, a, b, present);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    op             = 1'b0;
    first_char     = '0;
    second_char    = '0;
    second_present = 1'b0;
    squeeze_req    = 1'b0;
    no_gaps        = 1'b0;
    items_sent     = 0;
    tables_loaded  = 0;
    for (int i = 0; i < ROW_REGS; i++) key_img[i] = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Reset table: every cell holds the character zero.
    offer(OP_ENCRYPT, 8'h00, 8'h00, 1'b1);
    offer(OP_DECRYPT, 8'h00, 8'h00, 1'b1);
    offer(OP_ENCRYPT, 8'hFF, 8'h00, 1'b1);
    offer(OP_DECRYPT, 8'h00, 8'h00, 1'b0);
    drain();

    build_alphabet(1'b0);
    load_table();
    offer(OP_ENCRYPT, "A", "B", 1'b1);
    offer(OP_ENCRYPT, "E", "F", 1'b1);
    offer(OP_DECRYPT, "A", "F", 1'b1);
    offer(OP_ENCRYPT, "A", "G", 1'b1);
    offer(OP_ENCRYPT, "4", "A", 1'b1);
    offer(OP_DECRYPT, "A", "G", 1'b1);
    offer(OP_ENCRYPT, "A", "H", 1'b1);
    offer(OP_DECRYPT, "H", "A", 1'b1);
    offer(OP_ENCRYPT, "A", 8'h00, 1'b0);
    offer(OP_ENCRYPT, "A", "A", 1'b1);
    offer(OP_ENCRYPT, "X", "X", 1'b1);
    offer(OP_ENCRYPT, "X", 8'hFF, 1'b0);
    offer(OP_DECRYPT, "X", "X", 1'b1);
    offer(OP_DECRYPT, "A", "B", 1'b0);
    offer(OP_ENCRYPT, "Q", "A", 1'b1);
    offer(OP_ENCRYPT, "A", 8'hFF, 1'b1);
    offer(OP_DECRYPT, 8'h00, 8'hFF, 1'b1);
    offer(OP_DECRYPT, "9", "9", 1'b1);
    offer(OP_ENCRYPT, "9", "4", 1'b1);
    drain();

    build_alphabet(1'b1);
    load_table();
    random_pairs(200, 1'b0);
    drain();

    build_random(1'b0);
    load_table();
    random_pairs(150, 1'b0);
    drain();

    build_alphabet(1'b1);
    load_table();
    squeeze_req = 1'b1;
    random_pairs(150, 1'b1);
    drain();

    for (int i = 0; i < ROW_REGS; i++) next_rows[i] = '1;
    load_table();
    offer(OP_DECRYPT, 8'hFF, 8'hFF, 1'b1);
    random_pairs(50, 1'b0);
    drain();

    build_random(1'b1);
    next_rows[ROW_REGS-1] = '0;
    load_table();
    random_pairs(150, 1'b0);
    drain();

    build_alphabet(1'b1);
    load_table();
    random_pairs(250, 1'b0);
    drain();
    repeat (10) @(negedge clk);

    $display("Sent %0d digraphs, encrypt and decrypt, through %0d key tables with gaps",
             items_sent, tables_loaded);
    $display("and output stalls; %0d results checked, %0d of them with lookup_error.",
             checked, flagged);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- playfair_digraph_cipher.f -----
+incdir+sv
sv/pfc_pkg.sv
sv/pfc_key_regs.sv
sv/pfc_locate.sv
sv/pfc_digraph_map.sv
sv/playfair_digraph_cipher.sv
test/playfair_checker.sv
test/testbench.sv
